/* sv/rkc_pkg.sv */
// Shared types, constants and codes of the 3x3 RGB convolution core.
package rkc_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int COEF_FRAC_DEF = 8;

   localparam int PIX_W        = 24;
   localparam int CH_W         = 8;
   localparam int ROW_W        = 10;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int SIZE_W       = 11;
   localparam int COEF_W       = 16;
   localparam int KROW_W       = 48;
   localparam int CSR_IDX_W    = 3;
   localparam int PIX_MAX      = 255;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_K0     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_K1     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_K2     = 3'd4;

   localparam logic [2:0] OP_NONE      = 3'd0;
   localparam logic [2:0] OP_FILT      = 3'd1;
   localparam logic [2:0] OP_PASS      = 3'd2;
   localparam logic [2:0] OP_DRAIN_UP  = 3'd3;
   localparam logic [2:0] OP_DRAIN_MID = 3'd4;

   typedef struct packed {
      logic            func;
      logic [CH_W-1:0] red_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] blue_in;
   } rkc_req_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
      logic            last_of_frame;
   } rkc_rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic       last;
   } rkc_slot_type;

endpackage

/* sv/rkc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rkc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/rkc_ctrl.sv */
// Position counters, image size registers and per-item result decision.
module rkc_ctrl #(
   parameter int MAX_WIDTH = rkc_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr,
   input  logic [rkc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rkc_pkg::SIZE_W-1:0]     csr_size,
   input  logic                           accept,
   input  logic                           func,
   output rkc_pkg::rkc_slot_type          slot,
   output logic [$clog2(MAX_WIDTH)-1:0]   rd_addr
);
   import rkc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (SIZE_W > CW + 1) ? SIZE_W : CW + 1;
   localparam int PW = CW + 2;
   localparam int WIDTH_RST_M1 = (640 > MAX_WIDTH) ? MAX_WIDTH - 1 : 639;

   logic [CW-1:0]    w_m1_ff, w_m1_in;
   logic [ROW_W-1:0] h_m1_ff, h_m1_in;
   logic [CW-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [PW-1:0]    pend_ff, pend_in;
   logic [WW-1:0]    wv;
   logic [PW-1:0]    pend_inc;
   logic             out_edge, out_last;

   // clamp size writes to the supported range
   always_comb begin
      wv = WW'(csr_size);
      w_m1_in = w_m1_ff;
      h_m1_in = h_m1_ff;
      if (csr_wr && csr_index == REG_WIDTH) begin
         if (wv < WW'(3)) begin
            w_m1_in = CW'(2);
         end else if (wv > WW'(MAX_WIDTH)) begin
            w_m1_in = CW'(MAX_WIDTH - 1);
         end else begin
            w_m1_in = CW'(wv - WW'(1));
         end
      end
      if (csr_wr && csr_index == REG_HEIGHT) begin
         if (csr_size < SIZE_W'(3)) begin
            h_m1_in = ROW_W'(2);
         end else if (csr_size > SIZE_W'(HEIGHT_LIMIT)) begin
            h_m1_in = ROW_W'(HEIGHT_LIMIT - 1);
         end else begin
            h_m1_in = ROW_W'(csr_size - SIZE_W'(1));
         end
      end
   end

   assign out_edge = (out_col_ff == '0) || (out_col_ff == w_m1_ff) ||
                     (out_row_ff == '0) || (out_row_ff == h_m1_ff);
   assign out_last = (out_col_ff == w_m1_ff) && (out_row_ff == h_m1_ff);
   assign pend_inc = pend_ff + PW'(1);

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pend_in    = pend_ff;
      slot.op    = OP_NONE;
      slot.last  = out_last;
      rd_addr    = func ? out_col_ff : in_col_ff;
      if (csr_wr && (csr_index == REG_WIDTH || csr_index == REG_HEIGHT)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pend_in    = '0;
      end else if (accept) begin
         if (!func) begin
            if (in_col_ff == w_m1_ff) begin
               in_col_in = '0;
               in_row_in = (in_row_ff == h_m1_ff) ? '0 : in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
            pend_in = pend_inc;
            // lag reached one row plus one pixel: emit the next result
            if (pend_inc == PW'(w_m1_ff) + PW'(3)) begin
               pend_in = pend_ff;
               slot.op = out_edge ? OP_PASS : OP_FILT;
            end
         end else if (in_col_ff == '0 && in_row_ff == '0 && pend_ff != '0) begin
            pend_in = pend_ff - PW'(1);
            slot.op = (out_row_ff == h_m1_ff) ? OP_DRAIN_MID : OP_DRAIN_UP;
         end
         if (slot.op != OP_NONE) begin
            if (out_col_ff == w_m1_ff) begin
               out_col_in = '0;
               out_row_in = (out_row_ff == h_m1_ff) ? '0 : out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_m1_ff    <= CW'(WIDTH_RST_M1);
         h_m1_ff    <= ROW_W'(479);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= '0;
      end else begin
         w_m1_ff    <= w_m1_in;
         h_m1_ff    <= h_m1_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
      end
   end
endmodule

/* sv/rkc_filter.sv */
// Kernel multiply stage and sum, truncate and clamp of the three channels.
module rkc_filter #(
   parameter int COEF_FRAC_BITS = rkc_pkg::COEF_FRAC_DEF
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic [2:0][2:0][rkc_pkg::PIX_W-1:0]     win,
   input  logic [2:0][rkc_pkg::KROW_W-1:0]         kernel,
   output logic [rkc_pkg::PIX_W-1:0]               pix
);
   import rkc_pkg::*;

   localparam int PROD_W = CH_W + 1 + COEF_W;
   localparam int SUM_W  = PROD_W + 4;

   logic signed [PROD_W-1:0] prod_ff [3][3][3];
   logic signed [PROD_W-1:0] prod_in [3][3][3];
   logic signed [SUM_W-1:0]  sum [3];
   logic        [SUM_W-1:0]  q [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int h = 0; h < 3; h++) begin
            for (int v = 0; v < 3; v++) begin
               prod_in[c][h][v] = $signed({1'b0, win[h][v][c*CH_W +: CH_W]}) *
                                  $signed(kernel[h][v*COEF_W +: COEF_W]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = '0;
         for (int h = 0; h < 3; h++) begin
            for (int v = 0; v < 3; v++) begin
               sum[c] = sum[c] + SUM_W'(prod_ff[c][h][v]);
            end
         end
         q[c] = SUM_W'(sum[c] >>> COEF_FRAC_BITS);
         if (sum[c] <= 0) begin
            pix[c*CH_W +: CH_W] = '0;
         end else if (q[c] > SUM_W'(PIX_MAX)) begin
            pix[c*CH_W +: CH_W] = CH_W'(PIX_MAX);
         end else begin
            pix[c*CH_W +: CH_W] = q[c][CH_W-1:0];
         end
      end
   end
endmodule

/* sv/rgb_kernel_convolution_3x3_core.sv */
// Top level of the streaming 3x3 RGB convolution core.
// Takes one pixel per clock in raster order and returns one result per clock
// while rsp_ready is high; req_ready drops only when a result waits on the
// output. Results trail the input stream by one image row plus one pixel and
// are presented on rsp_valid after the pixel that releases them is accepted and
// passes the line memory read at the accept edge, the window update, the
// kernel multiply, and the sum and clamp into the output register. Two line
// memories of MAX_WIDTH pixels hold the two rows above the input; drain items
// flush the tail of a frame. Size and kernel writes are taken every cycle and
// must be done while the core is idle; a size write restarts the frame position.
module rgb_kernel_convolution_3x3_core #(
   parameter int MAX_WIDTH      = rkc_pkg::MAX_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = rkc_pkg::COEF_FRAC_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rkc_pkg::rkc_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rkc_pkg::rkc_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rkc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rkc_pkg::KROW_W-1:0]    csr_data
);
   import rkc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic                         adv, accept, csr_wr;
   rkc_slot_type                 s0_slot;
   logic [CW-1:0]                rd_addr;
   logic [2:0][KROW_W-1:0]       kernel_ff;

   rkc_slot_type                 s1_slot_ff, s2_slot_ff, s3_slot_ff;
   logic                         s1_wr_ff;
   logic [CW-1:0]                s1_col_ff;
   logic [PIX_W-1:0]             s1_pix_ff, s2_pix_ff, s3_pix_ff, s2_pix_in;
   logic                         fwd_hit_ff;
   logic [PIX_W-1:0]             fwd_up_ff, fwd_mid_ff;
   logic [PIX_W-1:0]             up_q, mid_q, up_rd, mid_rd;
   logic [2:0][2:0][PIX_W-1:0]   window_ff, window_in;
   logic [PIX_W-1:0]             filt_pix, out_pix;
   logic                         rsp_valid_ff;
   rkc_rsp_type                  rsp_data_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid;

   rkc_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_wr),
      .csr_index (csr_index),
      .csr_size  (csr_data[SIZE_W-1:0]),
      .accept    (accept),
      .func      (req_data.func),
      .slot      (s0_slot),
      .rd_addr   (rd_addr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= {KROW_W'(0), KROW_W'(48'd16777216), KROW_W'(0)};
      end else if (csr_wr) begin
         case (csr_index)
            REG_K0:  kernel_ff[0] <= csr_data;
            REG_K1:  kernel_ff[1] <= csr_data;
            REG_K2:  kernel_ff[2] <= csr_data;
            default: kernel_ff <= kernel_ff;
         endcase
      end
   end

   // upper row takes the old middle row, middle row takes the new pixel
   rkc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock   (clock),
      .wr_en   (adv && s1_wr_ff),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (up_q)
   );

   rkc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock   (clock),
      .wr_en   (adv && s1_wr_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (mid_q)
   );

   // forward a write that landed in the same cycle as this item's read
   assign up_rd  = fwd_hit_ff ? fwd_up_ff  : up_q;
   assign mid_rd = fwd_hit_ff ? fwd_mid_ff : mid_q;

   always_comb begin
      window_in[0]    = window_ff[1];
      window_in[1]    = window_ff[2];
      window_in[2][0] = up_rd;
      window_in[2][1] = mid_rd;
      window_in[2][2] = s1_pix_ff;
      case (s1_slot_ff.op)
         OP_DRAIN_UP:  s2_pix_in = up_rd;
         OP_DRAIN_MID: s2_pix_in = mid_rd;
         default:      s2_pix_in = window_ff[2][1];
      endcase
   end

   rkc_filter #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_filter (
      .clock  (clock),
      .en     (adv),
      .win    (window_ff),
      .kernel (kernel_ff),
      .pix    (filt_pix)
   );

   assign out_pix = (s3_slot_ff.op == OP_FILT) ? filt_pix : s3_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_slot_ff   <= '0;
         s2_slot_ff   <= '0;
         s3_slot_ff   <= '0;
         s1_wr_ff     <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
      end else if (adv) begin
         s1_slot_ff   <= accept ? s0_slot : rkc_slot_type'('0);
         s1_wr_ff     <= accept && !req_data.func;
         fwd_hit_ff   <= s1_wr_ff && (rd_addr == s1_col_ff);
         s2_slot_ff   <= s1_slot_ff;
         s3_slot_ff   <= s2_slot_ff;
         rsp_valid_ff <= s3_slot_ff.op != OP_NONE;
         if (s1_wr_ff) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff  <= rd_addr;
         s1_pix_ff  <= {req_data.red_in, req_data.green_in, req_data.blue_in};
         fwd_up_ff  <= mid_rd;
         fwd_mid_ff <= s1_pix_ff;
         s2_pix_ff  <= s2_pix_in;
         s3_pix_ff  <= s2_pix_ff;
         rsp_data_ff.red_out       <= out_pix[2*CH_W +: CH_W];
         rsp_data_ff.green_out     <= out_pix[CH_W +: CH_W];
         rsp_data_ff.blue_out      <= out_pix[0 +: CH_W];
         rsp_data_ff.last_of_frame <= s3_slot_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

/* dv/testbench.sv */
// Self-checking testbench for the streaming 3x3 RGB convolution core.
`timescale 1ns / 1ps

module testbench;
   import rkc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int ITEM_TARGET = 550;
   localparam int WIDE_ITEMS = 150;
   localparam int MAX_REPORTS = 10;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd5;
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rkc_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rkc_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [KROW_W-1:0] csr_data = '0;

   rgb_kernel_convolution_3x3_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // model state of the core
   logic [SIZE_W-1:0] cfg_width = 11'd640;
   logic [SIZE_W-1:0] cfg_height = 11'd480;
   logic [KROW_W-1:0] cfg_krow [3] = '{48'h0, 48'h0000_0100_0000, 48'h0};
   logic [PIX_W-1:0] upper_row [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] middle_row [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] win [3][3];
   int unsigned in_col, in_row, out_col, out_row;

   rkc_req_type pend_items [$];
   rkc_rsp_type want_pixels [$];

   int cycle_count = 0;
   int mismatches = 0;
   int results_seen = 0;
   int items_sent = 0;
   int frames_sent = 0;
   int gap_max = 13;
   int stall_max = 13;
   int req_gap = 0;
   int rsp_stall = 0;
   bit req_took = 0;
   bit rsp_took = 0;

   function automatic int unsigned used_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return cfg_width;
   endfunction

   function automatic int unsigned used_height();
      if (cfg_height < 3) return 3;
      if (cfg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return cfg_height;
   endfunction

   function automatic logic [CH_W-1:0] conv_channel(int sh);
      int sum;
      int coef;
      int q;
      sum = 0;
      for (int h = 0; h < 3; h++) begin
         for (int v = 0; v < 3; v++) begin
            coef = $signed(cfg_krow[h][16*v +: 16]);
            sum += int'(win[h][v][sh +: 8]) * coef;
         end
      end
      if (sum <= 0) return '0;
      q = sum >>> COEF_FRAC_DEF;
      return (q > PIX_MAX) ? 8'(PIX_MAX) : 8'(q);
   endfunction

   function automatic void step_pos(ref int unsigned col, ref int unsigned row,
                                    input int unsigned w, input int unsigned h);
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
   endfunction

   function automatic void emit_pixel(logic [PIX_W-1:0] pix, int unsigned w, int unsigned h);
      rkc_rsp_type r;
      r.red_out = pix[23:16];
      r.green_out = pix[15:8];
      r.blue_out = pix[7:0];
      r.last_of_frame = (out_col == w - 1 && out_row == h - 1);
      want_pixels.push_back(r);
      step_pos(out_col, out_row, w, h);
   endfunction

   function automatic void conv_predict_item(rkc_req_type it);
      int unsigned w, h, frame, in_idx, out_idx, pending, col;
      logic [PIX_W-1:0] pix;
      w = used_width();
      h = used_height();
      frame = w * h;
      if (it.func == FUNC_PIXEL) begin
         pix = {it.red_in, it.green_in, it.blue_in};
         col = (in_col < MAX_WIDTH_DEF) ? in_col : 0;
         win[0] = win[1];
         win[1] = win[2];
         win[2][0] = upper_row[col];
         win[2][1] = middle_row[col];
         win[2][2] = pix;
         upper_row[col] = middle_row[col];
         middle_row[col] = pix;
         step_pos(in_col, in_row, w, h);
         in_idx = in_row * w + in_col;
         out_idx = out_row * w + out_col;
         pending = (in_idx + frame - out_idx) % frame;
         if (pending != w + 2) return;
         if (out_col == 0 || out_col == w - 1 || out_row == 0 || out_row == h - 1)
            emit_pixel(win[1][1], w, h);
         else
            emit_pixel({conv_channel(16), conv_channel(8), conv_channel(0)}, w, h);
      end else begin
         if (in_col != 0 || in_row != 0) return;
         if (out_col == 0 && out_row == 0) return;
         col = (out_col < MAX_WIDTH_DEF) ? out_col : 0;
         emit_pixel((out_row == h - 1) ? middle_row[col] : upper_row[col], w, h);
      end
   endfunction

   function automatic void conv_apply_reg(logic [CSR_IDX_W-1:0] idx, logic [KROW_W-1:0] val);
      case (idx)
         REG_WIDTH, REG_HEIGHT: begin
            if (idx == REG_WIDTH) cfg_width = val[SIZE_W-1:0];
            else cfg_height = val[SIZE_W-1:0];
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
         end
         REG_K0: cfg_krow[0] = val;
         REG_K1: cfg_krow[1] = val;
         REG_K2: cfg_krow[2] = val;
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // accept items on both channels and check results in order
   always @(posedge clock) begin : sample
      rkc_rsp_type exp;
      if (!reset && req_valid && req_ready) begin
         conv_predict_item(req_data);
         req_took = 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_took = 1;
         results_seen++;
         if (want_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected item %h at cycle %0d", rsp_data, cycle_count);
         end else begin
            exp = want_pixels.pop_front();
            if (rsp_data.red_out !== exp.red_out || rsp_data.green_out !== exp.green_out ||
                rsp_data.blue_out !== exp.blue_out ||
                rsp_data.last_of_frame !== exp.last_of_frame) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("cycle %0d: expected %h %h %h last %b, got %h %h %h last %b",
                           cycle_count, exp.red_out, exp.green_out, exp.blue_out,
                           exp.last_of_frame, rsp_data.red_out, rsp_data.green_out,
                           rsp_data.blue_out, rsp_data.last_of_frame);
            end
         end
      end
   end

   always @(negedge clock) begin : drive_req
      logic nv;
      nv = req_valid;
      if (req_took) begin
         nv = 1'b0;
         req_took = 0;
      end
      if (!reset && !nv) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pend_items.size() > 0) begin
            req_data <= pend_items.pop_front();
            nv = 1'b1;
            req_gap = $urandom_range(0, gap_max);
         end
      end
      req_valid <= nv;
   end

   always @(negedge clock) begin : drive_rsp
      logic rv;
      rv = rsp_ready;
      if (reset) begin
         rv = 1'b0;
      end else if (rsp_took) begin
         rsp_took = 0;
         rsp_stall = $urandom_range(0, stall_max);
         rv = (rsp_stall == 0);
      end else if (!rv) begin
         if (rsp_stall > 0) rsp_stall--;
         rv = (rsp_stall == 0);
      end
      rsp_ready <= rv;
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [KROW_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      conv_apply_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pend_items.size() != 0 || req_valid || want_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_pixel(logic [PIX_W-1:0] p);
      rkc_req_type it;
      it.func = FUNC_PIXEL;
      {it.red_in, it.green_in, it.blue_in} = p;
      pend_items.push_back(it);
      items_sent++;
   endtask

   task automatic push_drain();
      rkc_req_type it;
      it.func = FUNC_DRAIN;
      {it.red_in, it.green_in, it.blue_in} = PIX_W'($urandom);
      pend_items.push_back(it);
      items_sent++;
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic logic [KROW_W-1:0] rand_kernel(int mode);
      logic [KROW_W-1:0] k;
      int c;
      k = '0;
      for (int i = 0; i < 3; i++) begin
         case (mode)
            0: k[16*i +: 16] = 16'($urandom);
            1: begin
               c = $urandom_range(0, 768) - 256;
               k[16*i +: 16] = c[15:0];
            end
            2: begin
               case ($urandom_range(0, 3))
                  0: k[16*i +: 16] = 16'h7FFF;
                  1: k[16*i +: 16] = 16'h8000;
                  2: k[16*i +: 16] = 16'h0000;
                  default: k[16*i +: 16] = 16'hFFFF;
               endcase
            end
            default: k[16*i +: 16] = (i == 1) ? 16'h0100 : 16'h0000;
         endcase
      end
      return k;
   endfunction

   task automatic send_frame(int unsigned npix, bit noise);
      for (int unsigned p = 0; p < npix; p++) begin
         if (noise && p > 0 && $urandom_range(0, 19) == 0) push_drain();
         push_pixel(rand_pixel());
      end
      frames_sent++;
   endtask

   task automatic random_phase();
      int unsigned w, h, nframes, mode;
      logic [SIZE_W-1:0] wr, hr;
      wr = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 2))
                                       : SIZE_W'($urandom_range(3, 9));
      hr = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 2))
                                       : SIZE_W'($urandom_range(3, 6));
      csr_write(REG_WIDTH, KROW_W'(wr));
      csr_write(REG_HEIGHT, KROW_W'(hr));
      mode = $urandom_range(0, 3);
      csr_write(REG_K0, rand_kernel(mode));
      csr_write(REG_K1, rand_kernel(mode));
      csr_write(REG_K2, rand_kernel(mode));
      if ($urandom_range(0, 3) == 0)
         csr_write(REG_SPARE + CSR_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      w = used_width();
      h = used_height();
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
         if (f == nframes - 1 && $urandom_range(0, 5) == 0) begin
            // broken frame: stop partway, drains are ignored
            send_frame($urandom_range(1, w * h - 1), 1);
            repeat ($urandom_range(1, 3)) push_drain();
            return;
         end
         send_frame(w * h, 1);
         // partial drain between frames, the next frame catches up
         if (f < nframes - 1 && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(0, w + 1)) push_drain();
      end
      if ($urandom_range(0, 4) != 0)
         repeat (w + 1 + $urandom_range(0, 2)) push_drain();
   endtask

   initial begin
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      win = '{default: '0};
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: clamped 3x3 frame with identity kernel, extremes and drains
      csr_write(REG_WIDTH, '0);
      csr_write(REG_HEIGHT, 48'd2);
      csr_write(REG_K0, '0);
      csr_write(REG_K1, 48'h0000_0100_0000);
      csr_write(REG_K2, '0);
      csr_write(REG_SPARE, '1);
      push_drain();
      push_pixel(24'h000000);
      push_pixel(24'hFFFFFF);
      push_pixel(24'h00FF00);
      push_drain();
      push_pixel(24'hFF00FF);
      repeat (5) push_pixel(rand_pixel());
      repeat (5) push_drain();
      wait_idle();

      // saturate high, then all negative with partial drain and catch-up
      csr_write(REG_K0, 48'h7FFF_7FFF_7FFF);
      csr_write(REG_K1, 48'h7FFF_7FFF_7FFF);
      csr_write(REG_K2, 48'h7FFF_7FFF_7FFF);
      send_frame(9, 0);
      repeat (4) push_drain();
      wait_idle();
      csr_write(REG_K0, 48'h8000_8000_8000);
      csr_write(REG_K1, 48'h8000_8000_8000);
      csr_write(REG_K2, 48'hFFFF_FFFF_FFFF);
      csr_write(REG_HEIGHT, 48'd3);
      repeat (9) push_pixel('1);
      repeat (2) push_drain();
      send_frame(9, 0);
      repeat (4) push_drain();
      wait_idle();

      while (items_sent < ITEM_TARGET - WIDE_ITEMS) begin
         random_phase();
         wait_idle();
      end

      // widest and tallest setting: a short run that is still inside the start-up lag
      gap_max = 2;
      stall_max = 2;
      csr_write(REG_WIDTH, 48'h7FF);
      csr_write(REG_HEIGHT, 48'd1024);
      csr_write(REG_K0, rand_kernel(1));
      csr_write(REG_K1, rand_kernel(1));
      csr_write(REG_K2, rand_kernel(1));
      repeat (WIDE_ITEMS) push_pixel(rand_pixel());
      wait_idle();

      $display("sent %0d items in %0d frames, checked %0d results", items_sent,
               frames_sent, results_seen);
      $display("covered sizes 3 to 1024 with clamping, random and extreme kernels, drains");
      if (mismatches == 0 && want_pixels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, want_pixels.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
